[rtl/jtag_tap_path_walker_macros.svh]
// assertion macros used by the walker rtl
`ifndef JTAG_TAP_PATH_WALKER_MACROS_SVH
`define JTAG_TAP_PATH_WALKER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold on every rising edge outside reset
`define JTPW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the same edge
`define JTPW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define JTPW_ASSERT(lbl, clk, rst_n, prop, msg)
`define JTPW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/jtpw_pkg.sv]
`timescale 1ns / 1ps

package jtpw_pkg;

  localparam int unsigned TAP_W            = 5;
  localparam int unsigned INIT_ONES        = 6;
  localparam int unsigned STEP_GUARD       = 10;
  localparam int unsigned JTPW_QUEUE_DEPTH = 2;

  typedef enum logic [TAP_W-1:0] {
    TAP_INIT      = 5'd0,
    TAP_RESET     = 5'd1,
    TAP_IDLE      = 5'd2,
    TAP_DRSELECT  = 5'd3,
    TAP_DRCAPTURE = 5'd4,
    TAP_DRSHIFT   = 5'd5,
    TAP_DREXIT1   = 5'd6,
    TAP_DRPAUSE   = 5'd7,
    TAP_DREXIT2   = 5'd8,
    TAP_DRUPDATE  = 5'd9,
    TAP_IRSELECT  = 5'd10,
    TAP_IRCAPTURE = 5'd11,
    TAP_IRSHIFT   = 5'd12,
    TAP_IREXIT1   = 5'd13,
    TAP_IRPAUSE   = 5'd14,
    TAP_IREXIT2   = 5'd15,
    TAP_IRUPDATE  = 5'd16
  } tap_state_e;

  typedef enum logic {
    WALK_IDLE,
    WALK_RUN
  } walk_state_e;

  // classified request handed from front to back
  typedef struct packed {
    logic [TAP_W-1:0] target;
    logic             ir_branch;
  } cmd_t;

  typedef struct packed {
    tap_state_e nxt;
    logic       tms;
  } edge_t;

  // one edge of the tap graph toward the target (init handled by caller)
  function automatic edge_t tap_edge(tap_state_e cur, logic [TAP_W-1:0] tgt,
                                     logic ir_branch);
    edge_t e;
    e.tms = 1'b1;
    e.nxt = TAP_RESET;
    case (cur)
      TAP_RESET:    begin e.tms = 1'b0; e.nxt = TAP_IDLE; end
      TAP_IDLE:     begin e.tms = 1'b1; e.nxt = TAP_DRSELECT; end
      TAP_DRSELECT: begin
        if (ir_branch) begin e.tms = 1'b1; e.nxt = TAP_IRSELECT; end
        else begin e.tms = 1'b0; e.nxt = TAP_DRCAPTURE; end
      end
      TAP_DRCAPTURE: begin
        if (tgt == TAP_DRSHIFT) begin e.tms = 1'b0; e.nxt = TAP_DRSHIFT; end
        else begin e.tms = 1'b1; e.nxt = TAP_DREXIT1; end
      end
      TAP_DRSHIFT:  begin e.tms = 1'b1; e.nxt = TAP_DREXIT1; end
      TAP_DREXIT1: begin
        if (tgt == TAP_DRPAUSE) begin e.tms = 1'b0; e.nxt = TAP_DRPAUSE; end
        else begin e.tms = 1'b1; e.nxt = TAP_DRUPDATE; end
      end
      TAP_DRPAUSE:  begin e.tms = 1'b1; e.nxt = TAP_DREXIT2; end
      TAP_DREXIT2: begin
        if (tgt == TAP_DRSHIFT) begin e.tms = 1'b0; e.nxt = TAP_DRSHIFT; end
        else begin e.tms = 1'b1; e.nxt = TAP_DRUPDATE; end
      end
      TAP_DRUPDATE, TAP_IRUPDATE: begin
        if (tgt == TAP_IDLE) begin e.tms = 1'b0; e.nxt = TAP_IDLE; end
        else begin e.tms = 1'b1; e.nxt = TAP_DRSELECT; end
      end
      TAP_IRSELECT: begin
        if (tgt == TAP_RESET) begin e.tms = 1'b1; e.nxt = TAP_RESET; end
        else begin e.tms = 1'b0; e.nxt = TAP_IRCAPTURE; end
      end
      TAP_IRCAPTURE: begin
        if (tgt == TAP_IRSHIFT) begin e.tms = 1'b0; e.nxt = TAP_IRSHIFT; end
        else begin e.tms = 1'b1; e.nxt = TAP_IREXIT1; end
      end
      TAP_IRSHIFT:  begin e.tms = 1'b1; e.nxt = TAP_IREXIT1; end
      TAP_IREXIT1: begin
        if (tgt == TAP_IRPAUSE) begin e.tms = 1'b0; e.nxt = TAP_IRPAUSE; end
        else begin e.tms = 1'b1; e.nxt = TAP_IRUPDATE; end
      end
      TAP_IRPAUSE:  begin e.tms = 1'b1; e.nxt = TAP_IREXIT2; end
      TAP_IREXIT2: begin
        if (tgt == TAP_IRSHIFT) begin e.tms = 1'b0; e.nxt = TAP_IRSHIFT; end
        else begin e.tms = 1'b1; e.nxt = TAP_IRUPDATE; end
      end
      default: begin e.tms = 1'b1; e.nxt = TAP_RESET; end
    endcase
    return e;
  endfunction

endpackage

[rtl/jtpw_front.sv]
`timescale 1ns / 1ps

module jtpw_front
  import jtpw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [TAP_W-1:0] in_target_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output cmd_t             cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;

  assign in_ready_o = !valid_q || cmd_ready_i;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (valid_q && cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d          = 1'b1;
      cmd_d.target     = in_target_i;
      // the ir branch is taken for any ir-group target, reset, or a code off the graph
      cmd_d.ir_branch  = (in_target_i >= TAP_W'(TAP_IRSELECT)) ||
                         (in_target_i == TAP_W'(TAP_RESET));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

[rtl/jtpw_queue.sv]
`timescale 1ns / 1ps

module jtpw_queue #(
  parameter int unsigned Width = 6,
  parameter int unsigned Depth = 2   // 2 to 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/jtpw_back.sv]
`timescale 1ns / 1ps
`include "jtag_tap_path_walker_macros.svh"

module jtpw_back
  import jtpw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic out_tms_o,
  output logic out_pulse_o,
  output logic out_last_o,
  output logic out_error_o
);

  localparam int unsigned StepW = $clog2(STEP_GUARD + 2);
  localparam int unsigned OnesW = $clog2(INIT_ONES);

  walk_state_e      state_q, state_d;
  tap_state_e       cur_q, cur_d;
  cmd_t             cmd_q, cmd_d;
  logic             first_q, first_d;
  logic [StepW-1:0] step_q, step_d;
  logic [OnesW-1:0] ones_q, ones_d;

  logic o_valid_q, o_valid_d;
  logic o_tms_q, o_tms_d, o_pulse_q, o_pulse_d;
  logic o_last_q, o_last_d, o_err_q, o_err_d;

  logic       slot_free;
  logic       step_end;
  tap_state_e step_nxt;
  logic       guard;
  edge_t      e;

  assign slot_free   = !o_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == WALK_IDLE);
  assign guard       = step_q > StepW'(STEP_GUARD);
  assign e           = tap_edge(cur_q, cmd_q.target, cmd_q.ir_branch);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    cmd_d     = cmd_q;
    first_d   = first_q;
    step_d    = step_q;
    ones_d    = ones_q;
    o_valid_d = o_valid_q && !out_ready_i;
    o_tms_d   = o_tms_q;
    o_pulse_d = o_pulse_q;
    o_last_d  = o_last_q;
    o_err_d   = o_err_q;
    step_end  = 1'b0;
    step_nxt  = cur_q;

    case (state_q)
      WALK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          first_d = 1'b1;
          step_d  = '0;
          ones_d  = '0;
          state_d = WALK_RUN;
        end
      end
      WALK_RUN: begin
        if (slot_free) begin
          o_valid_d = 1'b1;
          first_d   = 1'b0;
          if (first_q && (cmd_q.target == cur_q)) begin
            // already there: one item with no pulse
            o_tms_d   = 1'b0;
            o_pulse_d = 1'b0;
            o_last_d  = 1'b1;
            o_err_d   = 1'b0;
            state_d   = WALK_IDLE;
          end else begin
            o_pulse_d = 1'b1;
            o_last_d  = 1'b0;
            o_err_d   = 1'b0;
            if (cur_q == TAP_INIT || cur_q > TAP_IRUPDATE) begin
              // leaving init: a run of ones counts as a single step
              o_tms_d = 1'b1;
              if (ones_q == OnesW'(INIT_ONES - 1)) begin
                step_end = 1'b1;
                step_nxt = TAP_RESET;
              end else begin
                ones_d = ones_q + 1'b1;
              end
            end else begin
              o_tms_d  = e.tms;
              step_end = 1'b1;
              step_nxt = e.nxt;
            end
            if (step_end) begin
              cur_d    = step_nxt;
              step_d   = step_q + 1'b1;
              o_err_d  = guard;
              o_last_d = guard || (step_nxt == cmd_q.target);
              if (o_last_d) begin
                state_d = WALK_IDLE;
              end
            end
          end
        end
      end
      default: begin
        state_d = WALK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= WALK_IDLE;
      cur_q     <= TAP_INIT;
      first_q   <= 1'b0;
      step_q    <= '0;
      ones_q    <= '0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      first_q   <= first_d;
      step_q    <= step_d;
      ones_q    <= ones_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    o_tms_q   <= o_tms_d;
    o_pulse_q <= o_pulse_d;
    o_last_q  <= o_last_d;
    o_err_q   <= o_err_d;
  end

  assign out_valid_o = o_valid_q;
  assign out_tms_o   = o_tms_q;
  assign out_pulse_o = o_pulse_q;
  assign out_last_o  = o_last_q;
  assign out_error_o = o_err_q;

  `JTPW_ASSERT_IMPL(a_err_on_last, clk_i, rst_ni, o_valid_q && o_err_q, o_last_q,
                    "walk error raised on an item that is not the last")
  `JTPW_ASSERT_IMPL(a_nopulse_alone, clk_i, rst_ni, o_valid_q && !o_pulse_q,
                    o_last_q && !o_err_q && !o_tms_q, "no-move item malformed")
  `JTPW_ASSERT(a_step_bound, clk_i, rst_ni, step_q <= StepW'(STEP_GUARD + 2),
               "step counter ran past the guard")
  `JTPW_ASSERT_IMPL(a_no_pop_in_walk, clk_i, rst_ni, state_q == WALK_RUN,
                    !cmd_ready_o, "request taken while a walk is under way")

endmodule

[rtl/jtag_tap_path_walker.sv]
`timescale 1ns / 1ps

// JTAG TAP path walker: each input item names a target TAP state (0 init, 1 reset,
// 2 run-test/idle, 3..9 DR select..update, 10..16 IR select..update) and the block
// answers with the TMS bits, one item per TCK pulse, that walk the standard TAP
// graph from its tracked current state to that target. The tracked state resets to
// init; the first walk out of init starts with six ones to reach test-logic-reset.
// A target equal to the current state yields one item with pulse low. A walk that
// runs past eleven steps (only seen for target init or codes above 16) stops with
// walk_error on its last item, and the tracked state stays wherever it stopped.
// The front registers and classifies a target and hands it through a short
// request queue; the walker loads it into a register while idle, then issues one
// result item per cycle into its output register unless the output stalls, and
// takes no new target until the current walk has ended. The front keeps accepting
// targets while the walker is busy until the queue fills.
module jtag_tap_path_walker
  import jtpw_pkg::*;
#(
  parameter int unsigned QueueDepth = JTPW_QUEUE_DEPTH  // request queue entries, 2 to 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // target stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [4:0] target_state, [7:5] zero
  // tms stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [0] tms, [1] pulse, [7:2] zero
  output logic       m_axis_tlast_o,   // last item of a walk
  output logic       m_axis_tuser_o    // [0] walk_error
);

  // front to queue
  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  // queue to walker
  logic q_valid, q_ready;
  cmd_t q_cmd;
  // walker output
  logic tms, pulse;

  jtpw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_target_i (s_axis_tdata_i[TAP_W-1:0]),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  jtpw_queue #(
    .Width ($bits(cmd_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  // the walker owns the tracked tap state and the step guard
  jtpw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_tms_o   (tms),
    .out_pulse_o (pulse),
    .out_last_o  (m_axis_tlast_o),
    .out_error_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {6'b0, pulse, tms};

endmodule

[tb/tb_jtag_tap_path_walker.sv]
`timescale 1ns / 1ps

module tb_jtag_tap_path_walker;
  import jtpw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_PER_PHASE = 85;
  localparam int unsigned MAX_PRINTED = 50;

  // one expected tms item
  typedef struct packed {
    logic tms;
    logic pulse;
    logic last;
    logic walk_err;
  } tms_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       tgt_valid = 1'b0;
  logic       tgt_ready;
  logic [7:0] tgt_data = 8'h00;
  logic       tms_valid;
  logic       tms_ready = 1'b0;
  logic [7:0] tms_data;
  logic       tms_last;
  logic       tms_user;

  logic [TAP_W-1:0] target_fifo[$];  // targets still to be sent
  tms_item_t        walk_q[$];       // tms items still to come back
  logic [TAP_W-1:0] tap_now;         // tracked tap state of the predictor
  logic             target_taken = 1'b0;
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      mismatches = 0;
  int unsigned      cycles = 0;

  jtag_tap_path_walker dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (tgt_valid),
    .s_axis_tready_o (tgt_ready),
    .s_axis_tdata_i  (tgt_data),
    .m_axis_tvalid_o (tms_valid),
    .m_axis_tready_i (tms_ready),
    .m_axis_tdata_o  (tms_data),
    .m_axis_tlast_o  (tms_last),
    .m_axis_tuser_o  (tms_user)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("%0t ns mismatch: %s", $time, what);
  endtask

  // one edge of the tap graph toward tgt, returns {tms, next state}
  function automatic logic [TAP_W:0] next_hop(logic [TAP_W-1:0] cur, logic [TAP_W-1:0] tgt);
    case (cur)
      TAP_RESET:    return {1'b0, TAP_IDLE};
      TAP_IDLE:     return {1'b1, TAP_DRSELECT};
      TAP_DRSELECT: begin
        // ir side when the goal lies there, or for reset
        if (tgt >= TAP_IRSELECT || tgt == TAP_RESET) return {1'b1, TAP_IRSELECT};
        return {1'b0, TAP_DRCAPTURE};
      end
      TAP_DRCAPTURE: return (tgt == TAP_DRSHIFT) ? {1'b0, TAP_DRSHIFT} : {1'b1, TAP_DREXIT1};
      TAP_DRSHIFT:   return {1'b1, TAP_DREXIT1};
      TAP_DREXIT1:   return (tgt == TAP_DRPAUSE) ? {1'b0, TAP_DRPAUSE} : {1'b1, TAP_DRUPDATE};
      TAP_DRPAUSE:   return {1'b1, TAP_DREXIT2};
      TAP_DREXIT2:   return (tgt == TAP_DRSHIFT) ? {1'b0, TAP_DRSHIFT} : {1'b1, TAP_DRUPDATE};
      TAP_DRUPDATE, TAP_IRUPDATE: begin
        return (tgt == TAP_IDLE) ? {1'b0, TAP_IDLE} : {1'b1, TAP_DRSELECT};
      end
      TAP_IRSELECT:  return (tgt == TAP_RESET) ? {1'b1, TAP_RESET} : {1'b0, TAP_IRCAPTURE};
      TAP_IRCAPTURE: return (tgt == TAP_IRSHIFT) ? {1'b0, TAP_IRSHIFT} : {1'b1, TAP_IREXIT1};
      TAP_IRSHIFT:   return {1'b1, TAP_IREXIT1};
      TAP_IREXIT1:   return (tgt == TAP_IRPAUSE) ? {1'b0, TAP_IRPAUSE} : {1'b1, TAP_IRUPDATE};
      TAP_IRPAUSE:   return {1'b1, TAP_IREXIT2};
      TAP_IREXIT2:   return (tgt == TAP_IRSHIFT) ? {1'b0, TAP_IRSHIFT} : {1'b1, TAP_IRUPDATE};
      default:       return {1'b1, TAP_RESET};
    endcase
  endfunction

  // works out the tms items of one walk and moves the tracked state
  function automatic void plan_walk(logic [TAP_W-1:0] tgt);
    logic [TAP_W-1:0] cur;
    logic [TAP_W:0]   hop;
    logic             tms_bits[$];
    logic             hit_guard;
    int               steps;
    cur = tap_now;
    hit_guard = 1'b0;
    steps = 0;
    // already there: a single item without a pulse
    if (tgt == cur) begin
      walk_q.push_back('{tms: 1'b0, pulse: 1'b0, last: 1'b1, walk_err: 1'b0});
      return;
    end
    while (cur != tgt) begin
      if (cur == TAP_INIT || cur > TAP_IRUPDATE) begin
        // leaving init takes a run of ones into test-logic-reset
        repeat (INIT_ONES) tms_bits.push_back(1'b1);
        cur = TAP_RESET;
      end else begin
        hop = next_hop(cur, tgt);
        tms_bits.push_back(hop[TAP_W]);
        cur = hop[TAP_W-1:0];
      end
      // unreachable goals go round the graph until the guard trips
      if (steps > int'(STEP_GUARD)) begin
        hit_guard = 1'b1;
        break;
      end
      steps++;
    end
    tap_now = cur;
    foreach (tms_bits[k]) begin
      walk_q.push_back('{tms: tms_bits[k], pulse: 1'b1,
                         last: (k == tms_bits.size() - 1),
                         walk_err: (k == tms_bits.size() - 1) && hit_guard});
    end
  endfunction

  // target driver and tms ready driver, changes on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      tgt_valid <= 1'b0;
      tms_ready <= 1'b0;
    end else begin
      if (!tgt_valid || target_taken) begin
        if (target_fifo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          tgt_data  <= {3'b000, target_fifo.pop_front()};
          tgt_valid <= 1'b1;
        end else begin
          tgt_valid <= 1'b0;
        end
      end
      tms_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor: checks tms items and predicts on accepted targets
  always @(posedge clk) begin
    tms_item_t want;
    target_taken = 1'b0;
    if (rst_n) begin
      if (tms_valid && tms_ready) begin
        if (walk_q.size() == 0) begin
          report_mismatch($sformatf("tms item with none expected, data %h last %b user %b",
                                    tms_data, tms_last, tms_user));
        end else begin
          want = walk_q.pop_front();
          if (tms_data[0] !== want.tms)
            report_mismatch($sformatf("tms %b, expected %b", tms_data[0], want.tms));
          if (tms_data[1] !== want.pulse)
            report_mismatch($sformatf("pulse %b, expected %b", tms_data[1], want.pulse));
          if (tms_last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", tms_last, want.last));
          if (tms_user !== want.walk_err)
            report_mismatch($sformatf("walk_error %b, expected %b", tms_user, want.walk_err));
        end
      end
      if (tgt_valid && tgt_ready) begin
        target_taken = 1'b1;
        plan_walk(tgt_data[TAP_W-1:0]);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[jtag_tap_path_walker] ERROR");
      $finish;
    end
  end

  // mostly legal targets, some repeats of the last goal and a few unreachable codes
  function automatic logic [TAP_W-1:0] pick_target(logic [TAP_W-1:0] prev);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return prev;
    if (roll < 14) return TAP_INIT;
    if (roll < 17) return TAP_W'($urandom_range(17, 31));
    return TAP_W'($urandom_range(TAP_RESET, TAP_IRUPDATE));
  endfunction

  task automatic wait_targets_sent(bit with_results);
    while (target_fifo.size() != 0 || tgt_valid || (with_results && walk_q.size() != 0))
      @(posedge clk);
  endtask

  initial begin
    logic [TAP_W-1:0] last_goal;
    tap_now = TAP_INIT;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: init repeat, every state, shift and pause loops, unreachable goals
    target_fifo = '{TAP_INIT, TAP_RESET, TAP_RESET, TAP_IDLE, TAP_DRSELECT, TAP_DRCAPTURE,
                    TAP_DRSHIFT, TAP_DREXIT1, TAP_DRPAUSE, TAP_DREXIT2, TAP_DRUPDATE,
                    TAP_IRSELECT, TAP_IRCAPTURE, TAP_IRSHIFT, TAP_IREXIT1, TAP_IRPAUSE,
                    TAP_IREXIT2, TAP_IRUPDATE, TAP_DRPAUSE, TAP_DRSHIFT, TAP_IRPAUSE,
                    TAP_IRSHIFT, TAP_RESET, TAP_INIT, 5'd31, 5'd17, TAP_IDLE};
    last_goal = TAP_IDLE;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        last_goal = pick_target(last_goal);
        target_fifo.push_back(last_goal);
      end
      // wait until every target is sent; in phase 1 also until every expected item is back
      wait_targets_sent(phase == 1);
    end

    wait_targets_sent(1'b1);
    repeat (40) @(posedge clk);
    if (walk_q.size() != 0)
      report_mismatch($sformatf("%0d tms items never arrived", walk_q.size()));
    if (mismatches == 0) begin
      $display("[jtag_tap_path_walker] OK");
    end else begin
      $display("[jtag_tap_path_walker] ERROR");
    end
    $finish;
  end

endmodule
